FILE: hw/rtl/osr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the odd-row descending sorter.
// No dependencies; imported by osr_cell and odd_row_descending_sorter.
package osr_pkg;

    localparam int SIZE_W = 7;
    localparam int IDX_W  = 6;
    localparam int CMP_W  = SIZE_W + 1;

    typedef struct packed {
        logic ins;
        logic drain;
    } t_cell_ctrl;

endpackage

FILE: hw/rtl/odd_row_descending_sorter.sv
`timescale 1ns / 1ps
// Top level of the odd-row descending sorter: counters, output register
// and a chain of osr_cell instances. Depends on osr_pkg and osr_cell.
//
//  channel | valid        | flow control  | payload
//  --------+--------------+---------------+-----------------------------------
//  input   | i_in_valid   | o_in_stall    | i_value
//  output  | o_out_valid  | i_out_stall   | o_result_value, o_row_index,
//          |              |               | o_column_index, o_last_in_row
//  config  | i_cfg_valid  | o_cfg_ready   | i_cfg_data
//
// An item of an even row is passed to the output register.
// The item that ends an odd row is taken and then the row drains from the
// head cell of the chain, one result per cycle while the output is not blocked.
// Input is stalled while the row drains or the output register is blocked.
// Synchronous reset clears counters, drain flag and output valid; size is set to 64.
module odd_row_descending_sorter
    import osr_pkg::*;
#(
    parameter int MAX_N       = 64,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [VALUE_WIDTH-1:0] o_result_value,
    output logic        [IDX_W-1:0]       o_row_index,
    output logic        [IDX_W-1:0]       o_column_index,
    output logic                          o_last_in_row,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic        [SIZE_W-1:0]      i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_N + 1);

    logic [SIZE_W-1:0] r_size;
    logic [CNT_W-1:0]  r_count;
    logic [IDX_W-1:0]  r_col;
    logic [IDX_W-1:0]  r_row;
    logic              r_drain;
    logic [IDX_W-1:0]  r_drain_col;
    logic [IDX_W-1:0]  r_drain_row;
    logic              r_out_valid;
    logic signed [VALUE_WIDTH-1:0] r_out_value;
    logic [IDX_W-1:0]  r_out_row;
    logic [IDX_W-1:0]  r_out_col;
    logic              r_out_last;

    logic [SIZE_W-1:0] w_size;
    logic [SIZE_W-1:0] w_last_idx;
    logic              w_out_free;
    logic              w_in_acc;
    logic              w_row_end;
    logic              w_odd_row;
    logic              w_insert;
    logic              w_emit;
    logic              w_drain_last;
    logic              w_drain_hit;
    t_cell_ctrl        w_ctrl;

    logic signed [VALUE_WIDTH-1:0] w_cell_val   [MAX_N];
    logic                          w_cell_yield [MAX_N];

    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (r_size == '0) begin
            w_size = SIZE_W'(1);
        end else if (CMP_W'(r_size) > CMP_W'(MAX_N)) begin
            w_size = SIZE_W'(MAX_N);
        end else begin
            w_size = r_size;
        end
    end

    assign w_last_idx   = w_size - SIZE_W'(1);
    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall   = r_drain || !w_out_free;
    assign w_in_acc     = i_in_valid && !o_in_stall;
    assign w_row_end    = CMP_W'(r_col) >= CMP_W'(w_last_idx);
    assign w_odd_row    = r_row[0];
    assign w_insert     = w_in_acc && w_odd_row && (i_value != '0)
                          && (CMP_W'(r_count) < CMP_W'(MAX_N));
    assign w_emit       = r_drain && w_out_free;
    assign w_drain_last = CMP_W'(r_drain_col) >= CMP_W'(w_last_idx);
    assign w_drain_hit  = CMP_W'(r_drain_col) < CMP_W'(r_count);

    assign w_ctrl.ins   = w_insert;
    assign w_ctrl.drain = w_emit;

    for (genvar g = 0; g < MAX_N; g++) begin : g_chain
        logic signed [VALUE_WIDTH-1:0] w_left_val;
        logic                          w_left_yield;
        logic signed [VALUE_WIDTH-1:0] w_right_val;
        logic                          w_occ;

        if (g == 0) begin : g_head
            assign w_left_val   = '0;
            assign w_left_yield = 1'b0;
        end else begin : g_body
            assign w_left_val   = w_cell_val[g-1];
            assign w_left_yield = w_cell_yield[g-1];
        end

        if (g == MAX_N - 1) begin : g_tail
            assign w_right_val = w_cell_val[g];
        end else begin : g_inner
            assign w_right_val = w_cell_val[g+1];
        end

        assign w_occ = CMP_W'(g) < CMP_W'(r_count);

        osr_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl),
            .i_value       (i_value),
            .i_left_value  (w_left_val),
            .i_left_yield  (w_left_yield),
            .i_right_value (w_right_val),
            .i_occupied    (w_occ),
            .o_value       (w_cell_val[g]),
            .o_yield       (w_cell_yield[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= SIZE_W'(64);
            r_count     <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_drain     <= 1'b0;
            r_drain_col <= '0;
            r_drain_row <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_size <= i_cfg_data;
            end

            if (w_in_acc) begin
                if (w_row_end) begin
                    r_col <= '0;
                    if (CMP_W'(r_row) >= CMP_W'(w_last_idx)) begin
                        r_row <= '0;
                    end else begin
                        r_row <= r_row + IDX_W'(1);
                    end
                    if (w_odd_row) begin
                        r_drain     <= 1'b1;
                        r_drain_col <= '0;
                        r_drain_row <= r_row;
                    end
                end else begin
                    r_col <= r_col + IDX_W'(1);
                end
            end

            if (w_insert) begin
                r_count <= r_count + CNT_W'(1);
            end

            if (w_emit) begin
                r_drain_col <= r_drain_col + IDX_W'(1);
                if (w_drain_last) begin
                    r_drain <= 1'b0;
                    r_count <= '0;
                end
            end

            if ((w_in_acc && !w_odd_row) || w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_value <= w_drain_hit ? w_cell_val[0] : '0;
            r_out_row   <= r_drain_row;
            r_out_col   <= r_drain_col;
            r_out_last  <= w_drain_last;
        end else if (w_in_acc && !w_odd_row) begin
            r_out_value <= i_value;
            r_out_row   <= r_row;
            r_out_col   <= r_col;
            r_out_last  <= w_row_end;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_row_index    = r_out_row;
    assign o_column_index = r_out_col;
    assign o_last_in_row  = r_out_last;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= CMP_W'(MAX_N))
        else $error("Chain fill count exceeds the number of cells.");

    a_drain_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_odd_row && w_row_end) |=> r_drain)
        else $error("End of an odd row did not start a drain.");

    a_drain_col : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain |-> (CMP_W'(r_drain_col) < CMP_W'(w_size)))
        else $error("Drain column ran past the row length.");

    a_zero_fill : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && !w_drain_hit) |=> (o_out_valid && (o_result_value == '0)))
        else $error("Fill column past the gathered values is not zero.");

    a_no_accept_in_drain : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_drain && !w_drain_last) |=> !w_insert)
        else $error("Chain insert while a row is draining.");

endmodule

FILE: hw/rtl/osr_cell.sv
`timescale 1ns / 1ps
// One cell of the descending insertion chain: holds one value of the row.
// Depends on osr_pkg for the control struct.
module osr_cell
    import osr_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                          i_clk,
    input  t_cell_ctrl                    i_ctrl,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    input  logic signed [VALUE_WIDTH-1:0] i_left_value,
    input  logic                          i_left_yield,
    input  logic signed [VALUE_WIDTH-1:0] i_right_value,
    input  logic                          i_occupied,
    output logic signed [VALUE_WIDTH-1:0] o_value,
    output logic                          o_yield
);

    logic signed [VALUE_WIDTH-1:0] r_value;
    logic signed [VALUE_WIDTH-1:0] n_value;

    // A cell yields when it is empty or holds a value below the new one,
    // so equal values keep their arrival order.
    assign o_yield = !i_occupied || (r_value < i_value);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctrl.drain) begin
            n_value = i_right_value;
        end else if (i_ctrl.ins) begin
            if (i_left_yield) begin
                n_value = i_left_value;
            end else if (o_yield) begin
                n_value = i_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule
